### rtl/kmp_pkg.sv
// kmp_pkg: sizes, operation and status codes, and the structs shared by the
// KMP stream matcher modules. No dependencies.
package kmp_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 32;

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int OUT_POS_W = 32;
  localparam int POS_W     = POSITION_BITS;
  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_TEXT    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // memory access request from the sequencer to the pattern/fallback store
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_pat;
    logic [IDX_W-1:0]  wr_fb;
    logic [IDX_W-1:0]  pat_raddr;
    logic [IDX_W-1:0]  fb_raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_POS_W-1:0] pos;
    logic [STATUS_W-1:0]  status;
  } res_t;

endpackage

### rtl/kmp_in_if.sv
// kmp_in_if: input channel (operation, data byte) with valid/ready.
// Depends on kmp_pkg.
interface kmp_in_if;
  logic                      valid;
  logic                      ready;
  logic [kmp_pkg::OP_W-1:0]   operation;
  logic [kmp_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

### rtl/kmp_out_if.sv
// kmp_out_if: result channel (match flag, start position, status) with valid/ready.
// Depends on kmp_pkg.
interface kmp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         match_found;
  logic [kmp_pkg::OUT_POS_W-1:0] match_position;
  logic [kmp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output match_found, output match_position,
                  output status, input ready);
  modport sink   (input valid, input match_found, input match_position,
                  input status, output ready);
endinterface

### rtl/kmp_store.sv
// kmp_store: pattern byte memory and prefix (fallback) table memory,
// one write port shared by both, one registered read port each. Depends on kmp_pkg.
module kmp_store (
  input  logic                        clk,
  input  kmp_pkg::mem_req_t           req,
  output logic [kmp_pkg::BYTE_W-1:0]  pat_rd,
  output logic [kmp_pkg::IDX_W-1:0]   fb_rd
);

  logic [kmp_pkg::BYTE_W-1:0] pat_mem [kmp_pkg::MAX_PATTERN];
  logic [kmp_pkg::IDX_W-1:0]  fb_mem  [kmp_pkg::MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      pat_mem[req.wr_addr] <= req.wr_pat;
      fb_mem[req.wr_addr]  <= req.wr_fb;
    end
    pat_rd <= pat_mem[req.pat_raddr];
    fb_rd  <= fb_mem[req.fb_raddr];
  end

endmodule

### rtl/kmp_walk.sv
// kmp_walk: sequencer for the KMP matcher. Holds pattern length, build and
// match prefix lengths and the text index; walks the fallback chain one step
// per cycle through a single byte comparator. Depends on kmp_pkg, kmp_store.
module kmp_walk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kmp_pkg::OP_W-1:0]    in_op,
  input  logic [kmp_pkg::BYTE_W-1:0]  in_byte,
  output logic                        res_valid,
  input  logic                        res_ready,
  output kmp_pkg::res_t               res
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_FBRD, S_DONE} state_t;

  state_t                     state_r, state_nxt;
  kmp_pkg::op_t               op_r, op_nxt;
  logic [kmp_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [kmp_pkg::LEN_W-1:0]  pat_len_r, pat_len_nxt;
  logic [kmp_pkg::IDX_W-1:0]  build_len_r, build_len_nxt;
  logic [kmp_pkg::IDX_W-1:0]  match_len_r, match_len_nxt;
  logic [kmp_pkg::POS_W-1:0]  text_idx_r, text_idx_nxt;
  logic [kmp_pkg::IDX_W-1:0]  j_r, j_nxt;
  kmp_pkg::res_t              res_r, res_nxt;

  kmp_pkg::mem_req_t          req;
  logic [kmp_pkg::BYTE_W-1:0] pat_rd;
  logic [kmp_pkg::IDX_W-1:0]  fb_rd;
  logic [kmp_pkg::IDX_W-1:0]  j_start;
  logic                       eq;
  logic [kmp_pkg::LEN_W-1:0]  j_fin;
  logic [kmp_pkg::POS_W-1:0]  m_less1;
  logic [kmp_pkg::POS_W-1:0]  start_pos;
  logic [kmp_pkg::POS_W-1:0]  idx_inc;

  kmp_store u_store (
    .clk    (clk),
    .req    (req),
    .pat_rd (pat_rd),
    .fb_rd  (fb_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    pat_len_nxt   = pat_len_r;
    build_len_nxt = build_len_r;
    match_len_nxt = match_len_r;
    text_idx_nxt  = text_idx_r;
    j_nxt         = j_r;
    res_nxt       = res_r;

    j_start   = (kmp_pkg::op_t'(in_op) == kmp_pkg::OP_APPEND) ? build_len_r : match_len_r;
    eq        = (pat_rd == byte_r);
    j_fin     = kmp_pkg::LEN_W'(j_r) + kmp_pkg::LEN_W'(eq);
    m_less1   = kmp_pkg::POS_W'(pat_len_r) - kmp_pkg::POS_W'(1);
    start_pos = (text_idx_r >= m_less1) ? (text_idx_r - m_less1) : '0;
    idx_inc   = (text_idx_r != '1) ? (text_idx_r + kmp_pkg::POS_W'(1)) : text_idx_r;

    req           = '0;
    req.wr_addr   = pat_len_r[kmp_pkg::IDX_W-1:0];
    req.wr_pat    = byte_r;
    req.wr_fb     = j_fin[kmp_pkg::IDX_W-1:0];
    req.pat_raddr = j_r;
    req.fb_raddr  = j_r - kmp_pkg::IDX_W'(1);

    unique case (state_r)
      S_IDLE: begin
        req.pat_raddr = j_start;
        req.fb_raddr  = j_start - kmp_pkg::IDX_W'(1);
        if (in_valid) begin
          op_nxt   = kmp_pkg::op_t'(in_op);
          byte_nxt = in_byte;
          j_nxt    = j_start;
          res_nxt  = '0;
          unique case (kmp_pkg::op_t'(in_op))
            kmp_pkg::OP_CLEAR: begin
              pat_len_nxt   = '0;
              build_len_nxt = '0;
              match_len_nxt = '0;
              text_idx_nxt  = '0;
              state_nxt     = S_DONE;
            end
            kmp_pkg::OP_RESTART: begin
              match_len_nxt = '0;
              text_idx_nxt  = '0;
              state_nxt     = S_DONE;
            end
            kmp_pkg::OP_APPEND: begin
              priority if (pat_len_r == kmp_pkg::LEN_W'(kmp_pkg::MAX_PATTERN)) begin
                res_nxt.status = kmp_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end else if (pat_len_r == '0) begin
                req.wr_en     = 1'b1;
                req.wr_addr   = '0;
                req.wr_pat    = in_byte;
                req.wr_fb     = '0;
                build_len_nxt = '0;
                pat_len_nxt   = kmp_pkg::LEN_W'(1);
                state_nxt     = S_DONE;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            kmp_pkg::OP_TEXT: begin
              if (pat_len_r == '0) begin
                res_nxt.status = kmp_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_EVAL: begin
        if (!eq && (j_r != '0)) begin
          // mismatch: fall back one step, fetch the new position next cycle
          j_nxt         = fb_rd;
          req.pat_raddr = fb_rd;
          req.fb_raddr  = fb_rd - kmp_pkg::IDX_W'(1);
        end else if (op_r == kmp_pkg::OP_APPEND) begin
          req.wr_en     = 1'b1;
          build_len_nxt = j_fin[kmp_pkg::IDX_W-1:0];
          pat_len_nxt   = pat_len_r + kmp_pkg::LEN_W'(1);
          state_nxt     = S_DONE;
        end else begin
          text_idx_nxt = idx_inc;
          if (j_fin >= pat_len_r) begin
            res_nxt.found = 1'b1;
            res_nxt.pos   = kmp_pkg::OUT_POS_W'(start_pos);
            req.fb_raddr  = m_less1[kmp_pkg::IDX_W-1:0];
            state_nxt     = S_FBRD;
          end else begin
            match_len_nxt = j_fin[kmp_pkg::IDX_W-1:0];
            state_nxt     = S_DONE;
          end
        end
      end
      S_FBRD: begin
        match_len_nxt = fb_rd;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pat_len_r   <= '0;
      build_len_r <= '0;
      match_len_r <= '0;
      text_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      pat_len_r   <= pat_len_nxt;
      build_len_r <= build_len_nxt;
      match_len_r <= match_len_nxt;
      text_idx_r  <= text_idx_nxt;
    end
    op_r   <= op_nxt;
    byte_r <= byte_nxt;
    j_r    <= j_nxt;
    res_r  <= res_nxt;
  end

endmodule

### rtl/kmp_stream_matcher.sv
// KMP stream matcher top level: clear/append/text/restart transactions in, one
// result transaction out per input. Depends on kmp_pkg, kmp_in_if, kmp_out_if, kmp_walk.
// Path: clear, restart, refused or first append go from idle to the result state, then the
// output register; text byte or append pass the evaluate state first (fallback walk: one
// step a cycle), a text match also the fallback-read state. One transaction at a time.
// Reset (synchronous, rst_n low): pattern empty, match length and text index zero.
module kmp_stream_matcher (
  input  logic          clk,
  input  logic          rst_n,
  kmp_in_if.sink        in_if,
  kmp_out_if.source     out_if
);

  logic          res_valid;
  logic          res_ready;
  kmp_pkg::res_t res;

  logic          out_valid_r;
  kmp_pkg::res_t out_res_r;

  kmp_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_op     (in_if.operation),
    .in_byte   (in_if.data_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.match_found    = out_res_r.found;
  assign out_if.match_position = out_res_r.pos;
  assign out_if.status         = out_res_r.status;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("matcher ready right after accepting a transaction");

  a_status_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status != kmp_pkg::ST_OK) |-> !out_if.match_found)
    else $error("match reported with nonzero status");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.match_found |-> out_if.match_position == '0)
    else $error("nonzero position without a match");
`endif

endmodule

### dv/kmp_stream_checker.sv
`timescale 1ns / 1ps
// kmp_stream_checker: watches both channels of the KMP stream matcher, predicts
// the result of every input transaction and compares it field by field.
// Depends on kmp_pkg, kmp_in_if and kmp_out_if.
module kmp_stream_checker
  import kmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  kmp_in_if           in_mon,
  kmp_out_if          out_mon,
  output int unsigned fault_count,
  output int unsigned outstanding
);

  logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
  logic [IDX_W-1:0]  fb_mem  [MAX_PATTERN];
  int unsigned       pat_len;
  int unsigned       build_len;
  int unsigned       text_len;
  logic [POS_W-1:0]  text_pos;
  res_t              result_q [$];
  res_t              want;
  res_t              fresh;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fault_count++;
  endtask

  task automatic step_matcher(input op_t op, input logic [BYTE_W-1:0] b, output res_t r);
    int unsigned j;
    logic [63:0] start;
    r = '0;
    case (op)
      OP_CLEAR: begin
        pat_len   = 0;
        build_len = 0;
        text_len  = 0;
        text_pos  = '0;
      end
      OP_RESTART: begin
        text_len = 0;
        text_pos = '0;
      end
      OP_APPEND: begin
        if (pat_len >= MAX_PATTERN) begin
          r.status = ST_FULL;
        end else if (pat_len == 0) begin
          pat_mem[0] = b;
          fb_mem[0]  = '0;
          build_len  = 0;
          pat_len    = 1;
        end else begin
          j = build_len;
          while (j > 0 && b != pat_mem[j]) j = fb_mem[j-1];
          if (b == pat_mem[j]) j++;
          fb_mem[pat_len]  = IDX_W'(j);
          pat_mem[pat_len] = b;
          build_len        = j;
          pat_len++;
        end
      end
      default: begin
        if (pat_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          j = text_len;
          while (j > 0 && b != pat_mem[j]) j = fb_mem[j-1];
          if (b == pat_mem[j]) j++;
          if (j >= pat_len) begin
            r.found = 1'b1;
            start = (64'(text_pos) >= 64'(pat_len - 1)) ?
                    64'(text_pos) - 64'(pat_len - 1) : 64'd0;
            r.pos = start[OUT_POS_W-1:0];
            j = fb_mem[pat_len-1];
          end
          text_len = j;
          if (text_pos != '1) text_pos++;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_len     = 0;
      build_len   = 0;
      text_len    = 0;
      text_pos    = '0;
      fault_count = 0;
      result_q.delete();
      outstanding <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b pos=%0d status=%0d",
                                    out_mon.match_found, out_mon.match_position,
                                    out_mon.status));
        end else begin
          want = result_q.pop_front();
          if (out_mon.match_found !== want.found)
            report_mismatch($sformatf("match_found got %0b want %0b",
                                      out_mon.match_found, want.found));
          if (out_mon.match_position !== want.pos)
            report_mismatch($sformatf("match_position got %0d want %0d",
                                      out_mon.match_position, want.pos));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_mon.status, want.status));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        step_matcher(op_t'(in_mon.operation), in_mon.data_byte, fresh);
        result_q.push_back(fresh);
      end
      outstanding <= result_q.size();
    end
  end

endmodule

### dv/tb_kmp_stream_matcher.sv
`timescale 1ns / 1ps
// tb_kmp_stream_matcher: drives directed and random clear/append/text/restart
// transactions into kmp_stream_matcher with random stalls on both channels.
// Depends on kmp_pkg, kmp_in_if, kmp_out_if and kmp_stream_checker.
module tb_kmp_stream_matcher;
  import kmp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 500;

  logic        clk;
  logic        rst_n;
  logic        calm;
  int unsigned sent;
  int unsigned faults;
  int unsigned pending;
  int unsigned stall_cycles;

  kmp_in_if  in_ch ();
  kmp_out_if out_ch ();

  kmp_stream_matcher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  kmp_stream_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fault_count (faults),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("kmp_stream_matcher verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_txn(input op_t op, input logic [BYTE_W-1:0] b);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    calm <= (sent >= 250 && sent < 340);
    if (!calm && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 36);
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] sym [4];
    int plen;
    int tlen;
    int kind;
    sent            = 0;
    calm            <= 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_CLEAR;
    in_ch.data_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern, then a two-byte pattern with overlap and growth mid-text, then one byte
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_RESTART, 8'hFF);
    push_txn(OP_CLEAR, 8'h00);
    push_txn(OP_APPEND, 8'h00);
    push_txn(OP_APPEND, 8'hFF);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_APPEND, 8'h00);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_RESTART, 8'h5A);
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_TEXT, 8'hFF);
    push_txn(OP_TEXT, 8'h00);
    push_txn(OP_CLEAR, 8'hFF);
    push_txn(OP_APPEND, 8'hA5);
    push_txn(OP_TEXT, 8'hA5);
    push_txn(OP_TEXT, 8'hA5);
    push_txn(OP_TEXT, 8'h5A);

    // full pattern of one repeated byte: refused appends, then back-to-back matches
    sym[0] = 8'($urandom);
    push_txn(OP_CLEAR, 8'($urandom));
    repeat (MAX_PATTERN + 2) push_txn(OP_APPEND, sym[0]);
    repeat (MAX_PATTERN + 6) push_txn(OP_TEXT, sym[0]);

    while (sent < ITEM_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        for (int k = 0; k < 4; k++) sym[k] = 8'($urandom);
        if ($urandom_range(4) == 0) push_txn(OP_RESTART, 8'($urandom));
        else push_txn(OP_CLEAR, 8'($urandom));
        plen = ($urandom_range(9) == 0) ? $urandom_range(7, MAX_PATTERN + 1)
                                        : $urandom_range(1, 6);
        repeat (plen) push_txn(OP_APPEND, sym[$urandom_range(1)]);
        tlen = $urandom_range(6, 30) + ((plen > 6) ? plen : 0);
        for (int k = 0; k < tlen; k++) begin
          kind = $urandom_range(99);
          if (kind < 4) push_txn(OP_APPEND, sym[$urandom_range(1)]);
          else if (kind < 7) push_txn(OP_RESTART, 8'($urandom));
          else if (kind < 12) push_txn(OP_TEXT, sym[$urandom_range(3)]);
          else push_txn(OP_TEXT, sym[$urandom_range(1)]);
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 8)) push_txn(op_t'($urandom_range(3)), 8'($urandom));
      end else begin
        push_txn(OP_CLEAR, 8'($urandom));
        repeat ($urandom_range(1, 4)) push_txn(OP_TEXT, 8'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (faults == 0) begin
      $display("kmp_stream_matcher verification clean");
    end else begin
      $display("kmp_stream_matcher verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/kmp_pkg.sv
rtl/kmp_in_if.sv
rtl/kmp_out_if.sv
rtl/kmp_store.sv
rtl/kmp_walk.sv
rtl/kmp_stream_matcher.sv
dv/kmp_stream_checker.sv
dv/tb_kmp_stream_matcher.sv
